### hdl/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  localparam int unsigned LenW = 17;
  localparam int unsigned SmpW = 16;
  localparam int unsigned GridW = LenW + 1;
  localparam int unsigned QuoW = LenW;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned DefMaxLength = 65536;
  localparam int unsigned DefMaxUpsample = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_LEN  = 2'd0,
    REG_OUT_LEN = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    FR_IDLE,
    FR_GEN
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic signed [SmpW-1:0] prev_re;
    logic signed [SmpW-1:0] prev_im;
    logic signed [SmpW-1:0] cur_re;
    logic signed [SmpW-1:0] cur_im;
    logic [LenW-1:0]        num;
    logic [LenW-1:0]        den;
    logic                   direct;
    logic                   run_last;
    logic                   frame_last;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

### hdl/linear_resampler_unit.sv
`timescale 1ns / 1ps
// Linear resampler for complex 16-bit samples. A frame of in_length input beats
// on the input channel yields out_length output beats on an even grid from the
// first to the last input. Both channels use valid and stall; a beat moves when
// valid is high and stall is low. Length registers are written through the
// plain write port (index 0 in_length, index 1 out_length); the user must write
// them only while idle, which the block itself does not enforce, and a write
// while idle restarts the frame. Each input beat is taken in the idle state and
// held in the generate state, which pushes one interpolated output per cycle
// into the two-entry queue that decouples it from the back end, and waits while
// that queue is full. The back end computes one output at a time: a pass-through
// output goes straight to the output state, while an interpolated one first
// takes one multiply step and a 17-step restoring divider; this back-end work
// sets the output rate. Reset empties the queue, clears the frame position and
// previous sample, and sets both lengths to 2. When the receiver stalls, the
// output beat holds, the queue fills and the input channel then stalls in turn.
module linear_resampler_unit #(
  parameter int unsigned MAX_UPSAMPLE = lr_pkg::DefMaxUpsample
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [lr_pkg::LenW-1:0]         cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [lr_pkg::SmpW-1:0]  sample_re_i,
  input  logic signed [lr_pkg::SmpW-1:0]  sample_im_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [lr_pkg::SmpW-1:0]  out_re_o,
  output logic signed [lr_pkg::SmpW-1:0]  out_im_o,
  output logic                            run_last_o,
  output logic                            frame_last_o
);

  lr_pkg::q_wr_t qw;
  lr_pkg::q_rd_t qr;
  lr_pkg::cmd_t  cmd_wr, cmd_rd;
  logic          q_full, q_empty;

  lr_front #(
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_re_i(sample_re_i),
    .sample_im_i(sample_im_i),
    .qw_o       (qw),
    .q_full_i   (q_full),
    .cmd_o      (cmd_wr)
  );

  lr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (qw.push),
    .push_data_i(cmd_wr),
    .full_o     (q_full),
    .pop_i      (qr.pop),
    .pop_data_o (cmd_rd),
    .empty_o    (q_empty)
  );

  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qr_o        (qr),
    .q_empty_i   (q_empty),
    .cmd_i       (cmd_rd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .run_last_o  (run_last_o),
    .frame_last_o(frame_last_o)
  );

endmodule

### hdl/lr_queue.sv
`timescale 1ns / 1ps

module lr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lr_pkg::cmd_t  push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output lr_pkg::cmd_t  pop_data_o,
  output logic          empty_o
);

  lr_pkg::cmd_t mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o)
    else $error("queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count did not follow a push");

endmodule

### hdl/lr_front.sv
`timescale 1ns / 1ps

module lr_front #(
  parameter int unsigned MAX_UPSAMPLE = lr_pkg::DefMaxUpsample
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lr_pkg::LenW-1:0]          cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [lr_pkg::SmpW-1:0]   sample_re_i,
  input  logic signed [lr_pkg::SmpW-1:0]   sample_im_i,
  output lr_pkg::q_wr_t                    qw_o,
  input  logic                             q_full_i,
  output lr_pkg::cmd_t                     cmd_o
);

  localparam int unsigned LenW      = lr_pkg::LenW;
  localparam int unsigned GridW     = lr_pkg::GridW;
  localparam int unsigned MaxLength = lr_pkg::DefMaxLength;

  lr_pkg::fr_state_e st_q, st_d;

  logic [LenW-1:0]  in_len_q, out_len_q;
  logic [LenW-1:0]  seen_q, seen_d;
  logic [LenW-1:0]  done_q, done_d;
  logic [GridW-1:0] grid_q, grid_d;
  logic signed [lr_pkg::SmpW-1:0] prev_re_q, prev_im_q, prev_re_d, prev_im_d;
  logic signed [lr_pkg::SmpW-1:0] cur_re_q, cur_im_q;

  logic [31:0]      lin32, cap32, lout32;
  logic [LenW-1:0]  lin, lout, n_len, d_len;
  logic             in_acc, cfg_hit;
  logic             can_interp, final_pend, next_interp;
  logic [GridW-1:0] grid_next;

  always_comb begin
    lin32 = {15'd0, in_len_q};
    if (lin32 < 32'd2) lin32 = 32'd2;
    if (lin32 > 32'(MaxLength)) lin32 = 32'(MaxLength);
    cap32 = 32'(MAX_UPSAMPLE) * (lin32 - 32'd1) + 32'd1;
    if (cap32 > 32'(MaxLength)) cap32 = 32'(MaxLength);
    if (cap32 < 32'd2) cap32 = 32'd2;
    lout32 = {15'd0, out_len_q};
    if (lout32 < 32'd2) lout32 = 32'd2;
    if (lout32 > cap32) lout32 = cap32;
    lin   = lin32[LenW-1:0];
    lout  = lout32[LenW-1:0];
    n_len = lin - LenW'(1);
    d_len = lout - LenW'(1);
  end

  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == lr_pkg::REG_IN_LEN) ||
                                   (cfg_idx_i == lr_pkg::REG_OUT_LEN));
  assign grid_next  = grid_q + GridW'(n_len);
  assign can_interp = (seen_q != '0) && (done_q < lout) && (grid_q < GridW'(d_len));
  assign final_pend = ({1'b0, seen_q} + 18'd1) >= {1'b0, lin};
  assign next_interp = ({1'b0, done_q} + 18'd1 < {1'b0, lout}) &&
                       (grid_next < GridW'(d_len));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      lr_pkg::FR_IDLE: if (in_acc) st_d = lr_pkg::FR_GEN;
      lr_pkg::FR_GEN: begin
        if (!can_interp && !(final_pend && q_full_i)) st_d = lr_pkg::FR_IDLE;
      end
      default: st_d = lr_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (st_q != lr_pkg::FR_IDLE);
    qw_o.full  = q_full_i;
    qw_o.push  = 1'b0;
    cmd_o.prev_re    = prev_re_q;
    cmd_o.prev_im    = prev_im_q;
    cmd_o.cur_re     = cur_re_q;
    cmd_o.cur_im     = cur_im_q;
    cmd_o.num        = grid_q[LenW-1:0];
    cmd_o.den        = d_len;
    cmd_o.direct     = !can_interp;
    cmd_o.run_last   = can_interp ? (!next_interp && !final_pend) : 1'b1;
    cmd_o.frame_last = !can_interp;
    seen_d    = seen_q;
    done_d    = done_q;
    grid_d    = grid_q;
    prev_re_d = prev_re_q;
    prev_im_d = prev_im_q;
    unique case (st_q)
      lr_pkg::FR_IDLE: begin
        if (cfg_hit) begin
          seen_d = '0;
          done_d = '0;
          grid_d = '0;
        end
      end
      lr_pkg::FR_GEN: begin
        if (can_interp) begin
          if (!q_full_i) begin
            qw_o.push = 1'b1;
            done_d    = done_q + LenW'(1);
            grid_d    = grid_next;
          end
        end else if (!(final_pend && q_full_i)) begin
          qw_o.push = final_pend;
          prev_re_d = cur_re_q;
          prev_im_d = cur_im_q;
          if (final_pend) begin
            seen_d = '0;
            done_d = '0;
            grid_d = '0;
          end else begin
            seen_d = seen_q + LenW'(1);
            if (seen_q != '0) begin
              grid_d = (grid_q >= GridW'(d_len)) ? grid_q - GridW'(d_len) : '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= lr_pkg::FR_IDLE;
      in_len_q  <= LenW'(2);
      out_len_q <= LenW'(2);
      seen_q    <= '0;
      done_q    <= '0;
      grid_q    <= '0;
      prev_re_q <= '0;
      prev_im_q <= '0;
    end else begin
      st_q      <= st_d;
      seen_q    <= seen_d;
      done_q    <= done_d;
      grid_q    <= grid_d;
      prev_re_q <= prev_re_d;
      prev_im_q <= prev_im_d;
      if (cfg_we_i && (cfg_idx_i == lr_pkg::REG_IN_LEN)) in_len_q <= cfg_data_i;
      if (cfg_we_i && (cfg_idx_i == lr_pkg::REG_OUT_LEN)) out_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_re_q <= sample_re_i;
      cur_im_q <= sample_im_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) qw_o.push |-> !q_full_i)
    else $error("push into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qw_o.push && !cmd_o.direct) |-> (seen_q != '0))
    else $error("interpolation on the first input of a frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == lr_pkg::FR_GEN && can_interp) |-> (grid_q < GridW'(d_len)))
    else $error("grid offset out of segment");

endmodule

### hdl/lr_back.sv
`timescale 1ns / 1ps

module lr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output lr_pkg::q_rd_t                   qr_o,
  input  logic                            q_empty_i,
  input  lr_pkg::cmd_t                    cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [lr_pkg::SmpW-1:0]  out_re_o,
  output logic signed [lr_pkg::SmpW-1:0]  out_im_o,
  output logic                            run_last_o,
  output logic                            frame_last_o
);

  localparam int unsigned LenW = lr_pkg::LenW;
  localparam int unsigned SmpW = lr_pkg::SmpW;
  localparam int unsigned QuoW = lr_pkg::QuoW;
  localparam int unsigned CntW = $clog2(QuoW);
  localparam int unsigned NumW = 2 * LenW + 1;
  localparam int unsigned RemW = LenW + 1;

  lr_pkg::bk_state_e st_q, st_d;
  lr_pkg::cmd_t      cmd_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;

  logic [NumW-1:0]   nlo_q [2];
  logic [RemW-1:0]   rem_q [2];
  logic [QuoW-1:0]   quo_q [2];
  logic              neg_q [2];
  logic [RemW-1:0]   dsr_q;
  logic signed [SmpW-1:0] res_q [2];

  logic signed [SmpW:0]   diff [2];
  logic [LenW-1:0]        mag  [2];
  logic [2*LenW-1:0]      prod [2];
  logic [RemW:0]          rsh  [2];
  logic                   ge   [2];
  logic [RemW-1:0]        rem_n [2];
  logic [QuoW-1:0]        quo_n [2];
  logic signed [SmpW:0]   sum  [2];
  logic signed [SmpW-1:0] base [2];

  always_comb begin
    base[0] = cmd_q.prev_re;
    base[1] = cmd_q.prev_im;
    diff[0] = (SmpW+1)'(cmd_q.cur_re) - (SmpW+1)'(cmd_q.prev_re);
    diff[1] = (SmpW+1)'(cmd_q.cur_im) - (SmpW+1)'(cmd_q.prev_im);
    for (int k = 0; k < 2; k++) begin
      mag[k]   = diff[k][SmpW] ? LenW'(-diff[k]) : LenW'(diff[k]);
      prod[k]  = mag[k] * cmd_q.num;
      rsh[k]   = {rem_q[k], nlo_q[k][QuoW-1]};
      ge[k]    = rsh[k] >= {1'b0, dsr_q};
      rem_n[k] = ge[k] ? RemW'(rsh[k] - {1'b0, dsr_q}) : rsh[k][RemW-1:0];
      quo_n[k] = {quo_q[k][QuoW-2:0], ge[k]};
      sum[k]   = neg_q[k] ? (SmpW+1)'(base[k]) - (SmpW+1)'(quo_n[k])
                          : (SmpW+1)'(base[k]) + (SmpW+1)'(quo_n[k]);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      lr_pkg::BK_IDLE: begin
        if (!q_empty_i) st_d = cmd_i.direct ? lr_pkg::BK_OUT : lr_pkg::BK_MUL;
      end
      lr_pkg::BK_MUL:  st_d = lr_pkg::BK_DIV;
      lr_pkg::BK_DIV:  if (cnt_q == CntW'(QuoW - 1)) st_d = lr_pkg::BK_OUT;
      lr_pkg::BK_OUT:  if (!out_stall_i) st_d = lr_pkg::BK_IDLE;
      default: st_d = lr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = (st_q == lr_pkg::BK_IDLE) && !q_empty_i;
    qr_o.pop     = pop;
    qr_o.empty   = q_empty_i;
    out_valid_o  = (st_q == lr_pkg::BK_OUT);
    out_re_o     = res_q[0];
    out_im_o     = res_q[1];
    run_last_o   = cmd_q.run_last;
    frame_last_o = cmd_q.frame_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= lr_pkg::BK_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == lr_pkg::BK_MUL) cnt_q <= '0;
      else if (st_q == lr_pkg::BK_DIV) cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      lr_pkg::BK_IDLE: begin
        if (pop) begin
          cmd_q    <= cmd_i;
          res_q[0] <= cmd_i.cur_re;
          res_q[1] <= cmd_i.cur_im;
        end
      end
      lr_pkg::BK_MUL: begin
        dsr_q <= {cmd_q.den, 1'b0};
        for (int k = 0; k < 2; k++) begin
          nlo_q[k] <= {prod[k], 1'b0} + NumW'(cmd_q.den);
          rem_q[k] <= RemW'(({prod[k], 1'b0} + NumW'(cmd_q.den)) >> QuoW);
          quo_q[k] <= '0;
          neg_q[k] <= diff[k][SmpW];
        end
      end
      lr_pkg::BK_DIV: begin
        for (int k = 0; k < 2; k++) begin
          nlo_q[k] <= nlo_q[k] << 1;
          rem_q[k] <= rem_n[k];
          quo_q[k] <= quo_n[k];
          if (cnt_q == CntW'(QuoW - 1)) res_q[k] <= sum[k][SmpW-1:0];
        end
      end
      lr_pkg::BK_OUT: ;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> run_last_o)
    else $error("frame end without run end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == lr_pkg::BK_DIV) |-> (cnt_q < CntW'(QuoW)))
    else $error("divider step count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (st_q == lr_pkg::BK_MUL || st_q == lr_pkg::BK_OUT))
    else $error("command taken without starting work");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lr_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE3 = 2'd3;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandomItems = 150;

  typedef struct {
    logic signed [SmpW-1:0] re;
    logic signed [SmpW-1:0] im;
    logic                   run_last;
    logic                   frame_last;
  } out_beat_t;

  typedef struct {
    bit                     is_cfg;
    logic [CfgIdxW-1:0]     idx;
    logic [LenW-1:0]        data;
    logic signed [SmpW-1:0] re;
    logic signed [SmpW-1:0] im;
    bit                     typed;
    logic signed [SmpW-1:0] t_re;
    logic signed [SmpW-1:0] t_im;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [LenW-1:0]        cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [SmpW-1:0] sample_re_i = '0;
  logic signed [SmpW-1:0] sample_im_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [SmpW-1:0] out_re_o;
  logic signed [SmpW-1:0] out_im_o;
  logic                   run_last_o;
  logic                   frame_last_o;

  out_beat_t   pending_beats[$];
  int unsigned failures = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned frames_out = 0;
  int unsigned cfg_writes = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  logic [LenW-1:0] len_in_reg, len_out_reg;
  longint          prev_re, prev_im;
  longint unsigned seen, done_cnt, grid;

  linear_resampler_unit uut (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint lerp(longint a, longint b, longint unsigned num,
                                  longint unsigned den);
    longint          diff;
    longint unsigned mag, q;
    diff = b - a;
    mag = longint'(diff < 0 ? -diff : diff) * num;
    q = (2 * mag + den) / (2 * den);
    return diff < 0 ? a - longint'(q) : a + longint'(q);
  endfunction

  task automatic apply_cfg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] data);
    if (idx == REG_IN_LEN || idx == REG_OUT_LEN) begin
      if (idx == REG_IN_LEN) len_in_reg = data;
      else len_out_reg = data;
      seen = 0;
      done_cnt = 0;
      grid = 0;
    end
  endtask

  task automatic predict_sample(logic signed [SmpW-1:0] re, logic signed [SmpW-1:0] im);
    longint unsigned lin, lout, cap, n, d;
    out_beat_t       b;
    int              first;
    first = pending_beats.size();
    lin = len_in_reg < 2 ? 2 : (len_in_reg > DefMaxLength ? DefMaxLength : len_in_reg);
    cap = DefMaxUpsample * (lin - 1) + 1;
    if (cap > DefMaxLength) cap = DefMaxLength;
    lout = len_out_reg < 2 ? 2 : (len_out_reg > cap ? cap : len_out_reg);
    n = lin - 1;
    d = lout - 1;
    if (seen != 0) begin
      while (done_cnt < lout && grid < d) begin
        b.re = SmpW'(lerp(prev_re, re, grid, d));
        b.im = SmpW'(lerp(prev_im, im, grid, d));
        b.run_last = 1'b0;
        b.frame_last = 1'b0;
        pending_beats.push_back(b);
        done_cnt++;
        grid += n;
      end
      grid = grid >= d ? grid - d : 0;
    end
    seen++;
    prev_re = re;
    prev_im = im;
    if (seen >= lin) begin
      b.re = re;
      b.im = im;
      b.run_last = 1'b0;
      b.frame_last = 1'b1;
      pending_beats.push_back(b);
      seen = 0;
      done_cnt = 0;
      grid = 0;
    end
    if (pending_beats.size() > first) pending_beats[$].run_last = 1'b1;
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] data);
    wait (pending_beats.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    apply_cfg(idx, data);
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(logic signed [SmpW-1:0] re, logic signed [SmpW-1:0] im,
                             bit typed, logic signed [SmpW-1:0] t_re,
                             logic signed [SmpW-1:0] t_im);
    bit stalled;
    int first;
    @(posedge clk_i);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    in_valid_i <= 1'b0;
    first = pending_beats.size();
    predict_sample(re, im);
    if (typed && pending_beats.size() > first) begin
      pending_beats[first].re = t_re;
      pending_beats[first].im = t_im;
    end
    beats_in++;
  endtask

  function automatic logic signed [SmpW-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return SmpW'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    int unsigned held;
    if (hold_req) begin
      out_stall_i <= 1'b1;
      held = 0;
      while (held < HoldCycles) begin
        @(posedge clk_i);
        held++;
      end
      hold_req <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && $urandom_range(99) < 18;
    end
  end

  always @(negedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (frame_last_o) frames_out++;
      if (pending_beats.size() == 0) begin
        $error("unexpected output beat re=%0d im=%0d", out_re_o, out_im_o);
        failures++;
      end else begin
        e = pending_beats.pop_front();
        if (out_re_o !== e.re) begin
          $error("out_re expected %0d actual %0d", e.re, out_re_o);
          failures++;
        end
        if (out_im_o !== e.im) begin
          $error("out_im expected %0d actual %0d", e.im, out_im_o);
          failures++;
        end
        if (run_last_o !== e.run_last) begin
          $error("run_last expected %0b actual %0b", e.run_last, run_last_o);
          failures++;
        end
        if (frame_last_o !== e.frame_last) begin
          $error("frame_last expected %0b actual %0b", e.frame_last, frame_last_o);
          failures++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t   rows[$];
    stim_row_t   r;
    int unsigned sent, frame_len, count;
    apply_cfg(REG_IN_LEN, 2);
    apply_cfg(REG_OUT_LEN, 2);
    prev_re = 0;
    prev_im = 0;
    rows = '{
      '{0, REG_IN_LEN, 0, 16'sh7fff, 16'sh8000, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 16'sh8000, 16'sh7fff, 1, 16'sh7fff, 16'sh8000},
      '{1, REG_SPARE2, 5, 0, 0, 0, 0, 0},
      '{1, REG_IN_LEN, 0, 0, 0, 0, 0, 0},
      '{1, REG_OUT_LEN, 17'h1ffff, 0, 0, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 16'sh8000, 16'sh8000, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 16'sh7fff, 16'sh7fff, 1, 16'sh8000, 16'sh8000},
      '{1, REG_IN_LEN, 5, 0, 0, 0, 0, 0},
      '{1, REG_OUT_LEN, 5, 0, 0, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 100, -200, 0, 0, 0},
      '{0, REG_IN_LEN, 0, -7, 3, 1, 100, -200},
      '{0, REG_IN_LEN, 0, 16'sh7fff, 0, 1, -7, 3},
      '{0, REG_IN_LEN, 0, 0, 16'sh8000, 1, 16'sh7fff, 0},
      '{0, REG_IN_LEN, 0, 1, -1, 1, 0, 16'sh8000},
      '{1, REG_IN_LEN, 7, 0, 0, 0, 0, 0},
      '{1, REG_OUT_LEN, 3, 0, 0, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 1000, 1001, 0, 0, 0},
      '{0, REG_IN_LEN, 0, -3, 5, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 12345, -12345, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 16'sh8000, 16'sh7fff, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 3, 4, 0, 0, 0},
      '{0, REG_IN_LEN, 0, -1, -1, 0, 0, 0},
      '{0, REG_IN_LEN, 0, 9, -9, 0, 0, 0},
      '{1, REG_SPARE3, 0, 0, 0, 0, 0, 0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) write_cfg(r.idx, r.data);
      else send_sample(r.re, r.im, r.typed, r.t_re, r.t_im);
    end

    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(9))
        0: write_cfg(REG_IN_LEN, $urandom_range(1) ? 17'h1ffff : LenW'($urandom_range(1)));
        1: write_cfg(REG_SPARE2, LenW'($urandom));
        default: write_cfg(REG_IN_LEN, LenW'($urandom_range(2, 9)));
      endcase
      case ($urandom_range(9))
        0: write_cfg(REG_OUT_LEN, 17'h1ffff);
        1: write_cfg(REG_OUT_LEN, LenW'($urandom_range(1)));
        default: write_cfg(REG_OUT_LEN, LenW'($urandom_range(2, 40)));
      endcase
      frame_len = len_in_reg < 2 ? 2 : (len_in_reg > 9 ? 6 : len_in_reg);
      count = $urandom_range(3) == 0 ? $urandom_range(1, frame_len) : frame_len;
      repeat (count) begin
        calm = sent >= 100 && sent < 130;
        if (sent == 40) hold_req = 1'b1;
        if (sent == 80) wait (pending_beats.size() == 0);
        send_sample(rand_sample(), rand_sample(), 0, 0, 0);
        sent++;
      end
    end
    calm = 1'b0;
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d input beats over %0d register writes.", beats_in, cfg_writes);
    $display("Checked %0d output beats closing %0d frames.", beats_out, frames_out);
    if (failures == 0 && pending_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
